@@ rtl/core/order_book_best_price_tracker_macros.svh @@
// Assertion macros for the order book tracker checker.
// Depends on nothing; included by the checker file only.
`ifndef ORDER_BOOK_BEST_PRICE_TRACKER_MACROS_SVH
`define ORDER_BOOK_BEST_PRICE_TRACKER_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define OBT_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define OBT_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/core/obt_pkg.sv @@
// Shared types and constants for the order book tracker.
// No dependencies.
`default_nettype none
package obt_pkg;
	localparam int unsigned PriceW = 12;
	localparam int unsigned QtyW   = 32;
	localparam int unsigned IdW    = 10;

	localparam logic       OP_ADD    = 1'b0;
	localparam logic       OP_CANCEL = 1'b1;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOT_LIVE = 2'd2;

	typedef struct packed {
		logic              opcode;
		logic              side;
		logic [PriceW-1:0] price;
		logic [QtyW-1:0]   quantity;
		logic [IdW-1:0]    cancel_id;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [IdW-1:0]    order_id;
		logic              order_side;
		logic [PriceW-1:0] order_price;
		logic [QtyW-1:0]   order_qty;
		logic              bid_valid;
		logic [PriceW-1:0] top_bid;
		logic              ask_valid;
		logic [PriceW-1:0] top_ask;
	} out_item_t;
endpackage
`default_nettype wire

@@ rtl/core/obt_queue.sv @@
// Two-entry request queue between front and back.
// Depends on obt_pkg.
`default_nettype none
module obt_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              wr_valid,
	output logic             wr_ready,
	input  obt_pkg::in_item_t wr_data,
	output logic             rd_valid,
	input  wire              rd_ready,
	output obt_pkg::in_item_t rd_data
);
	import obt_pkg::*;
	in_item_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/obt_front.sv @@
// Front: accepts requests, masks price, pushes into queue.
// Depends on obt_pkg.
`default_nettype none
module obt_front #(
	parameter int unsigned PRICE_BITS = 12
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  obt_pkg::in_item_t in_data,
	output logic             q_valid,
	input  wire              q_ready,
	output obt_pkg::in_item_t q_data
);
	import obt_pkg::*;
	in_item_t item_q;
	in_item_t in_masked;
	logic     full_q;

	assign in_ready = !full_q || q_ready;
	assign q_valid  = full_q;
	assign q_data   = item_q;

	always_comb begin
		in_masked = in_data;
		// only the low PRICE_BITS bits of the price address a level
		for (int b = 0; b < PriceW; b++)
			if (b >= PRICE_BITS) in_masked.price[b] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (in_ready) full_q <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_q <= in_masked;
	end
endmodule
`default_nettype wire

@@ rtl/core/obt_back.sv @@
// Back: order table, free stack, level counts, bitmaps and best-price search.
// Depends on obt_pkg.
`default_nettype none
module obt_back #(
	parameter int unsigned CAPACITY   = 1024,
	parameter int unsigned PRICE_BITS = 12
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               q_valid,
	output logic              q_ready,
	input  obt_pkg::in_item_t q_data,
	output logic              out_valid,
	input  wire               out_ready,
	output obt_pkg::out_item_t out_data
);
	import obt_pkg::*;
	localparam int unsigned CapW   = $clog2(CAPACITY);
	localparam int unsigned CntW   = CapW + 1;
	localparam int unsigned Levels = 1 << PRICE_BITS;
	localparam int unsigned LeafN  = (Levels + 63) / 64;
	localparam int unsigned LeafW  = (PRICE_BITS > 6) ? PRICE_BITS - 6 : 1;
	localparam int unsigned SumN   = (LeafN + 63) / 64;
	localparam int unsigned SumA   = $clog2(2*SumN);
	localparam int unsigned LcA    = PRICE_BITS + 1;

	localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_UPD = 3'd2,
		S_BID = 3'd3, S_ASK = 3'd4, S_OUT = 3'd5, S_CLR = 3'd6;

	// memories
	logic [PriceW-1:0] price_mem [CAPACITY];
	logic [QtyW-1:0]   qty_mem   [CAPACITY];
	logic              side_mem  [CAPACITY];
	logic              live_mem  [CAPACITY];
	logic [CapW-1:0]   stack_mem [CAPACITY];
	logic [CntW-1:0]   lvl_mem   [2*Levels];
	logic [63:0]       leaf_mem  [2*LeafN];
	logic [63:0]       sum_q [2*SumN];

	logic [2:0]        st_q;
	in_item_t          it_q;
	logic [CntW-1:0]   free_q;
	logic [CapW-1:0]   id_q;
	logic [PriceW-1:0] rp_q;
	logic [QtyW-1:0]   rq_q;
	logic              rs_q;
	logic              live_rd_q;
	logic [CapW-1:0]   popid_q;
	logic [CntW-1:0]   lvl_q;
	logic [63:0]       leaf_q;
	logic [1:0]        status_q;
	logic              bad_q;
	logic [LcA:0]      clr_q;
	logic              bv_q, av_q;
	logic [PriceW-1:0] bid_q;
	logic [LeafW-1:0]  bw_q;
	logic [63:0]       bl_q;
	out_item_t         res_q;
	logic              ov_q;

	// derived
	logic              e_side;
	logic [PriceW-1:0] e_price;
	logic [LeafW-1:0]  e_w;
	logic [LcA-1:0]    e_la;
	logic [SumA-1:0]   s_idx;
	logic [IdW-1:0]    cid;
	logic              cid_ok;

	assign cid    = q_data.cancel_id;
	assign cid_ok = ({{(32-IdW){1'b0}}, it_q.cancel_id} < CAPACITY);
	assign e_side  = it_q.opcode == OP_ADD ? it_q.side : rs_q;
	assign e_price = it_q.opcode == OP_ADD ? it_q.price : rp_q;
	assign e_w  = e_price[LeafW+5:6];
	assign e_la = {e_side, e_price[PRICE_BITS-1:0]};
	assign s_idx = SumA'({e_side, e_w} >> 6);

	function automatic logic [5:0] hi_bit(input logic [63:0] v);
		logic [5:0] r;
		r = 6'd0;
		for (int i = 0; i < 64; i++) if (v[i]) r = 6'(i);
		return r;
	endfunction
	function automatic logic [5:0] lo_bit(input logic [63:0] v);
		logic [5:0] r;
		r = 6'd63;
		for (int i = 63; i >= 0; i--) if (v[i]) r = 6'(i);
		return r;
	endfunction

	// summary search: buy side highest, sell side lowest (few words)
	logic           sb_f, sa_f;
	logic [LeafW-1:0] sb_w, sa_w;
	always_comb begin
		sb_f = 1'b0; sa_f = 1'b0; sb_w = '0; sa_w = '0;
		for (int i = 0; i < SumN; i++)
			if (sum_q[i] != 64'd0) begin
				sb_f = 1'b1;
				sb_w = LeafW'((i << 6) + hi_bit(sum_q[i]));
			end
		for (int i = SumN-1; i >= 0; i--)
			if (sum_q[SumN+i] != 64'd0) begin
				sa_f = 1'b1;
				sa_w = LeafW'((i << 6) + lo_bit(sum_q[SumN+i]));
			end
	end

	logic [63:0] leaf_new;
	logic [5:0]  eb;
	assign eb = e_price[5:0];
	always_comb begin
		leaf_new = leaf_q;
		if (it_q.opcode == OP_ADD) begin
			leaf_new[eb] = 1'b1;
		end else if (lvl_q <= CntW'(1)) begin
			leaf_new[eb] = 1'b0;
		end
	end

	assign q_ready   = (st_q == S_IDLE);
	assign out_valid = ov_q;
	assign out_data  = res_q;

	// leaf word address: best bid or ask word in search states, entry word otherwise
	logic [LeafW:0] lf_ra;
	always_comb begin
		unique case (st_q)
			S_BID:   lf_ra = {1'b0, sb_w};
			S_ASK:   lf_ra = {1'b1, sa_w};
			default: lf_ra = {e_side, e_w};
		endcase
	end

	always_ff @(posedge clk) begin
		leaf_q <= leaf_mem[lf_ra[LeafW:0] & {1'b1, {LeafW{1'b1}}}];
		// search leaf held while the result waits
		if (st_q == S_BID || st_q == S_ASK) bl_q <= leaf_mem[lf_ra];
		if (st_q == S_IDLE && q_valid) begin
			rp_q      <= price_mem[cid[CapW-1:0]];
			rq_q      <= qty_mem[cid[CapW-1:0]];
			rs_q      <= side_mem[cid[CapW-1:0]];
			live_rd_q <= live_mem[cid[CapW-1:0]];
			popid_q   <= stack_mem[CapW'(free_q - CntW'(1))];
		end
		if (st_q == S_READ) lvl_q <= lvl_mem[e_la];
		if (st_q == S_UPD && !bad_q) begin
			lvl_mem[e_la] <= (it_q.opcode == OP_ADD) ? lvl_q + CntW'(1) :
				((lvl_q != '0) ? lvl_q - CntW'(1) : lvl_q);
			leaf_mem[{e_side, e_w}] <= leaf_new;
			if (it_q.opcode == OP_ADD) begin
				price_mem[popid_q] <= it_q.price;
				qty_mem[popid_q]   <= it_q.quantity;
				side_mem[popid_q]  <= it_q.side;
				live_mem[popid_q]  <= 1'b1;
			end else begin
				stack_mem[free_q[CapW-1:0]] <= id_q;
				live_mem[id_q] <= 1'b0;
			end
		end
		if (st_q == S_CLR) begin
			lvl_mem[clr_q[LcA-1:0]] <= '0;
			if (clr_q < (LcA+1)'(2*LeafN)) leaf_mem[clr_q[LeafW:0]] <= '0;
			if (clr_q < (LcA+1)'(CAPACITY)) begin
				stack_mem[clr_q[CapW-1:0]] <= CapW'(CAPACITY - 1) - clr_q[CapW-1:0];
				live_mem[clr_q[CapW-1:0]] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; clr_q <= '0; free_q <= CntW'(CAPACITY);
			ov_q <= 1'b0;
			for (int i = 0; i < 2*SumN; i++) sum_q[i] <= '0;
		end else begin
			if (st_q == S_OUT && (!ov_q || out_ready)) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + (LcA+1)'(1);
					if (clr_q == (LcA+1)'(2*Levels - 1)) st_q <= S_IDLE;
				end
				S_IDLE: if (q_valid) begin
					it_q <= q_data;
					id_q <= cid[CapW-1:0];
					st_q <= S_READ;
				end
				S_READ: begin
					if (it_q.opcode == OP_ADD) begin
						bad_q    <= (free_q == '0);
						status_q <= (free_q == '0) ? ST_FULL : ST_OK;
					end else begin
						bad_q    <= !(cid_ok && live_rd_q);
						status_q <= (cid_ok && live_rd_q) ? ST_OK : ST_NOT_LIVE;
					end
					st_q <= S_UPD;
				end
				S_UPD: begin
					if (!bad_q) begin
						if (it_q.opcode == OP_ADD) begin
							free_q <= free_q - CntW'(1);
							sum_q[s_idx] <= sum_q[s_idx] | (64'd1 << e_w[5:0]);
						end else begin
							free_q <= free_q + CntW'(1);
							if (leaf_new == 64'd0)
								sum_q[s_idx] <= sum_q[s_idx] & ~(64'd1 << e_w[5:0]);
						end
					end
					st_q <= S_BID;
				end
				S_BID: begin
					bv_q <= sb_f; bw_q <= sb_w;
					st_q <= S_ASK;
				end
				S_ASK: begin
					bid_q <= bv_q ? PriceW'({bw_q, hi_bit(bl_q)}) : '0;
					av_q  <= sa_f;
					bw_q  <= sa_w;
					st_q  <= S_OUT;
				end
				S_OUT: if (!ov_q || out_ready) begin
					res_q.status      <= status_q;
					res_q.order_id    <= (it_q.opcode == OP_ADD) ?
						(bad_q ? '0 : IdW'(popid_q)) : it_q.cancel_id;
					res_q.order_side  <= (it_q.opcode == OP_CANCEL && bad_q) ? 1'b0 : e_side;
					res_q.order_price <= (it_q.opcode == OP_CANCEL && bad_q) ? '0 : e_price;
					res_q.order_qty   <= (it_q.opcode == OP_ADD) ? it_q.quantity :
						(bad_q ? '0 : rq_q);
					res_q.bid_valid   <= bv_q;
					res_q.top_bid     <= bid_q;
					res_q.ask_valid   <= av_q;
					res_q.top_ask     <= av_q ? PriceW'({bw_q, lo_bit(bl_q)}) : '0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/order_book_best_price_tracker.sv @@
// Top level of the order book tracker: front, request queue, back.
// Depends on obt_pkg, obt_front, obt_queue, obt_back.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+----------------------
//  request | in_valid  | in_ready  | in_data  (in_item_t)
//  result  | out_valid | out_ready | out_data (out_item_t)
//
// Sequence: the back sequencer takes each request through accept with table read,
//   level count and leaf read, update, bid leaf read, ask leaf read and result,
//   set by the single port of the level count and leaf memories.
// Reset: a clearing pass sweeps level counts, leaf words, live flags and the
//   free stack; requests queue at the front meanwhile.
// Stalls: a waiting result holds the back in its result state; the front and
//   queue keep taking up to three requests meanwhile.
`default_nettype none
module order_book_best_price_tracker #(
	parameter int unsigned CAPACITY   = 1024,
	parameter int unsigned PRICE_BITS = 12
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  obt_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output obt_pkg::out_item_t out_data
);
	import obt_pkg::*;
	logic     fq_valid, fq_ready, qb_valid, qb_ready;
	in_item_t fq_data, qb_data;

	obt_front #(.PRICE_BITS(PRICE_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));

	obt_queue u_queue (
		.clk, .arst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data));

	obt_back #(.CAPACITY(CAPACITY), .PRICE_BITS(PRICE_BITS)) u_back (
		.clk, .arst_n, .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
		.out_valid, .out_ready, .out_data);
endmodule
`default_nettype wire

@@ rtl/core/obt_checker.sv @@
// Port-level checker for the order book tracker, bound to the top level.
// Depends on obt_pkg and the macros header.
`default_nettype none
`include "order_book_best_price_tracker_macros.svh"
module obt_checker (
	input wire                clk,
	input wire                arst_n,
	input wire                out_valid,
	input wire                out_ready,
	input obt_pkg::out_item_t out_data
);
	import obt_pkg::*;
	`OBT_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "unstable")
	`OBT_ASSERT_IMP(a_status, out_valid, out_data.status <= ST_NOT_LIVE, "bad status code")
	`OBT_ASSERT_IMP(a_bid0, out_valid && !out_data.bid_valid, out_data.top_bid == '0, "empty bid")
	`OBT_ASSERT_IMP(a_ask0, out_valid && !out_data.ask_valid, out_data.top_ask == '0, "empty ask")
endmodule

bind order_book_best_price_tracker obt_checker u_chk (
	.clk, .arst_n, .out_valid, .out_ready, .out_data);
`default_nettype wire
